@@ rtl/ssr_pkg.sv @@
// ============================================================================
// ssr_pkg
// Shared widths, request kinds and move codes for the servo step ramp.
// ============================================================================
package ssr_pkg;

    // field widths
    localparam int unsigned POS_W   = 8;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned CADDR_W = 2;

    // stream widths, packed from bit 0 up and padded to whole bytes
    localparam int unsigned S_DATA_W = 24;
    localparam int unsigned M_DATA_W = 16;

    // request kinds carried in s_tuser
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CMD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START = 2'd2;

    // move codes
    localparam logic [CODE_W-1:0] MOVE_STOP      = 3'd0;
    localparam logic [CODE_W-1:0] MOVE_UP_ONCE   = 3'd1;
    localparam logic [CODE_W-1:0] MOVE_DOWN_ONCE = 3'd2;
    localparam logic [CODE_W-1:0] MOVE_UP_CONT   = 3'd3;
    localparam logic [CODE_W-1:0] MOVE_DOWN_CONT = 3'd4;

    // configuration register indexes
    localparam logic [CADDR_W-1:0] CFG_LOW_LIMIT  = 2'd0;
    localparam logic [CADDR_W-1:0] CFG_HIGH_LIMIT = 2'd1;
    localparam logic [CADDR_W-1:0] CFG_REVERSE    = 2'd2;

    // one result item
    typedef struct packed {
        logic              moving;
        logic [CODE_W-1:0] ended_code;
        logic [POS_W-1:0]  position;
    } ssr_result_t;

endpackage

@@ rtl/servo_step_ramp_with_limits.sv @@
// ============================================================================
// servo_step_ramp_with_limits
// Steps a servo compare value between configured limits under tick,
// command and start requests.
// ============================================================================
//
// Usage:
//   s_ channel: one request per transaction. s_tuser holds the request kind
//   (tick, new command, start preset); s_tdata holds move code, step size
//   and tick delay. Every request gives exactly one result on the m_
//   channel: position, the code that ended at a limit, and the moving flag.
//   cfg channel: writes low_limit, high_limit and reverse_dir by index,
//   always ready; write only while no request is in flight.
//   The result is registered and shows in the cycle after the request;
//   throughput is one request per cycle while results are taken, set by the
//   single result register behind the update logic. A request is taken while
//   a result waits, as long as that result is taken in the same cycle.
//   Reset (aresetn low, synchronous) clears position, command, countdown
//   and limits to 0 / 255 / forward, and drops m_tvalid.
//   When the receiver stalls the result holds and s_tready goes low.
//
module servo_step_ramp_with_limits (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // move_code[2:0], step_amount[10:3], tick_delay[18:11], zero pad
    input  logic [ssr_pkg::S_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [ssr_pkg::REQ_W-1:0]     s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // position[7:0], ended_code[10:8], moving[11], zero pad
    output logic [ssr_pkg::M_DATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ssr_pkg::CADDR_W-1:0]   cfg_addr,
    input  logic [ssr_pkg::POS_W-1:0]     cfg_data
);
    import ssr_pkg::*;

    // configuration
    logic [POS_W-1:0] low_reg, high_reg;
    logic             rev_reg;

    // motion state
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              active_reg, active_next;
    logic [POS_W-1:0]  step_reg, step_next;
    logic [POS_W-1:0]  delay_reg, delay_next;
    logic [POS_W-1:0]  wait_reg, wait_next;

    // result register
    logic        out_valid_reg;
    ssr_result_t out_reg, out_next;

    // request fields
    logic [CODE_W-1:0] in_code, in_code_sw;
    logic [POS_W-1:0]  in_step, in_delay;
    logic              s_accept;

    // move datapath
    logic              is_up, is_down;
    logic [POS_W:0]    up_sum, dn_diff;
    logic              up_fits, dn_fits;
    logic [POS_W-1:0]  clamp_pos;
    logic [CODE_W-1:0] ended;

    assign in_code  = s_tdata[CODE_W-1:0];
    assign in_step  = s_tdata[CODE_W+POS_W-1:CODE_W];
    assign in_delay = s_tdata[CODE_W+2*POS_W-1:CODE_W+POS_W];

    // handshakes
    assign s_tready  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_DATA_W - POS_W - CODE_W - 1){1'b0}}, out_reg};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '0;
            high_reg <= '1;
            rev_reg  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_LOW_LIMIT:  low_reg  <= cfg_data;
                CFG_HIGH_LIMIT: high_reg <= cfg_data;
                CFG_REVERSE:    rev_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // direction swap for new commands
    always_comb begin
        in_code_sw = in_code;
        if (rev_reg) begin
            case (in_code)
                MOVE_UP_ONCE:   in_code_sw = MOVE_DOWN_ONCE;
                MOVE_DOWN_ONCE: in_code_sw = MOVE_UP_ONCE;
                MOVE_UP_CONT:   in_code_sw = MOVE_DOWN_CONT;
                MOVE_DOWN_CONT: in_code_sw = MOVE_UP_CONT;
                default:        in_code_sw = in_code;
            endcase
        end
    end

    // step arithmetic, one bit wider so nothing wraps
    assign is_up   = (code_reg == MOVE_UP_ONCE) || (code_reg == MOVE_UP_CONT);
    assign is_down = (code_reg == MOVE_DOWN_ONCE) || (code_reg == MOVE_DOWN_CONT);
    assign up_sum  = {1'b0, pos_reg} + {1'b0, step_reg};
    assign dn_diff = {1'b0, pos_reg} - {1'b0, step_reg};
    assign up_fits = up_sum <= {1'b0, high_reg};
    assign dn_fits = !dn_diff[POS_W] && (dn_diff[POS_W-1:0] >= low_reg);

    // a position already outside the limits snaps back to the near limit
    always_comb begin
        if (pos_reg < low_reg) begin
            clamp_pos = low_reg;
        end else if (pos_reg > high_reg) begin
            clamp_pos = high_reg;
        end else begin
            clamp_pos = is_up ? up_sum[POS_W-1:0] : dn_diff[POS_W-1:0];
        end
    end

    // next state per request
    always_comb begin
        pos_next    = pos_reg;
        code_next   = code_reg;
        active_next = active_reg;
        step_next   = step_reg;
        delay_next  = delay_reg;
        wait_next   = wait_reg;
        ended       = MOVE_STOP;
        case (s_tuser)
            REQ_TICK: begin
                if (wait_reg != '0) begin
                    wait_next = wait_reg - POS_W'(1);
                end else if (active_reg) begin
                    wait_next = delay_reg;
                    if (is_up || is_down) begin
                        if ((is_up && up_fits) || (is_down && dn_fits)) begin
                            pos_next = clamp_pos;
                            if ((code_reg == MOVE_UP_ONCE) || (code_reg == MOVE_DOWN_ONCE)) begin
                                active_next = 1'b0;
                            end
                        end else begin
                            pos_next    = is_up ? high_reg : low_reg;
                            code_next   = MOVE_STOP;
                            active_next = 1'b0;
                            ended       = code_reg;
                        end
                    end else begin
                        active_next = 1'b0;
                    end
                end
            end
            REQ_CMD: begin
                step_next   = in_step;
                delay_next  = in_delay;
                code_next   = in_code_sw;
                active_next = (in_code_sw >= MOVE_UP_ONCE) && (in_code_sw <= MOVE_DOWN_CONT);
                wait_next   = '0;
            end
            REQ_START: begin
                pos_next = rev_reg ? low_reg : high_reg;
            end
            default: ;
        endcase
        out_next.position   = pos_next;
        out_next.ended_code = ended;
        out_next.moving     = active_next;
    end

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            code_reg   <= MOVE_STOP;
            active_reg <= 1'b0;
            step_reg   <= '0;
            delay_reg  <= '0;
            wait_reg   <= '0;
        end else if (s_accept) begin
            pos_reg    <= pos_next;
            code_reg   <= code_next;
            active_reg <= active_next;
            step_reg   <= step_next;
            delay_reg  <= delay_next;
            wait_reg   <= wait_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_reg <= out_next;
        end
    end

endmodule

@@ rtl/ssr_checker.sv @@
// ============================================================================
// ssr_checker
// Port-level checks for the servo step ramp, bound to the top level.
// ============================================================================
module ssr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ssr_pkg::M_DATA_W-1:0]  m_tdata
);
    import ssr_pkg::*;

    // a stalled result holds its transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an ended command is no longer moving
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[POS_W+CODE_W-1:POS_W] != MOVE_STOP) |-> !m_tdata[POS_W+CODE_W])
        else $error("ended command still reported moving");

    // only real move codes can end at a limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[POS_W+CODE_W-1:POS_W] <= MOVE_DOWN_CONT)
        else $error("ended code out of range");

    // an empty or draining result stage always takes a request
    assert property (@(posedge aclk)
        !m_tvalid || m_tready |-> s_tready)
        else $error("request blocked with free result stage");

    // every accepted request shows a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request gave no result");

endmodule

bind servo_step_ramp_with_limits ssr_checker u_ssr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/servo_step_ramp_with_limits_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// servo_step_ramp_with_limits_tb
// Self-checking bench for the servo step ramp: drives tick, command, start
// and unused requests under random idling and backpressure, predicts each
// result from its own copy of the ramp state and limits, compares field by field.
// ============================================================================
module servo_step_ramp_with_limits_tb;
    import ssr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int LONG_STALL_LEN  = 80;
    localparam int MAX_ERROR_LINES = 30;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_CADENCE, RX_RARE} rx_pattern_e;

    // clock, reset and block ports
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic [REQ_W-1:0]     s_tuser   = REQ_TICK;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CADDR_W-1:0]   cfg_addr  = CFG_LOW_LIMIT;
    logic [POS_W-1:0]     cfg_data  = '0;

    // ramp state as the block should hold it
    logic [POS_W-1:0]  servo_pos  = '0;
    logic [CODE_W-1:0] run_code   = MOVE_STOP;
    logic              run_flag   = 1'b0;
    logic [7:0]        run_step   = '0;
    logic [7:0]        run_delay  = '0;
    logic [7:0]        tick_wait  = '0;
    logic [POS_W-1:0]  lim_low    = 8'd0;
    logic [POS_W-1:0]  lim_high   = 8'd255;
    logic              lim_rev    = 1'b0;

    ssr_result_t pending_results[$];
    int          error_count  = 0;
    int          idle_cycles  = 0;

    // sender pacing
    int burst_left  = 0;
    bit steady_feed = 1'b0;

    // receiver pacing
    int          long_stall_req  = 0;
    int          long_stall_seen = 0;
    int          stall_left      = 0;
    int          mode_left       = 0;
    int          cadence_cnt     = 0;
    rx_pattern_e rx_mode         = RX_ALWAYS;

    servo_step_ramp_with_limits u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // one line per mismatch, capped so a broken block cannot flood the log
    task automatic report_mismatch(input string msg);
        if (error_count < MAX_ERROR_LINES) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    // bring an out-of-range old position back inside the limits
    function automatic void clamp_from(input logic [POS_W-1:0] old_pos);
        if (old_pos < lim_low) begin
            servo_pos = lim_low;
        end else if (old_pos > lim_high) begin
            servo_pos = lim_high;
        end
    endfunction

    function automatic logic [CODE_W-1:0] apply_reverse(input logic [CODE_W-1:0] code);
        if (!lim_rev) return code;
        case (code)
            MOVE_UP_ONCE:   return MOVE_DOWN_ONCE;
            MOVE_DOWN_ONCE: return MOVE_UP_ONCE;
            MOVE_UP_CONT:   return MOVE_DOWN_CONT;
            MOVE_DOWN_CONT: return MOVE_UP_CONT;
            default:        return code;
        endcase
    endfunction

    // advance the ramp by one request and give the result it must produce
    function automatic ssr_result_t ramp_next(input logic [REQ_W-1:0] req,
                                              input logic [CODE_W-1:0] code,
                                              input logic [7:0] step,
                                              input logic [7:0] delay);
        ssr_result_t       res;
        logic [CODE_W-1:0] ended;
        logic [CODE_W-1:0] mc;
        logic [POS_W-1:0]  old_pos;
        logic [8:0]        up_sum;
        int                down_diff;
        ended = MOVE_STOP;
        case (req)
            REQ_TICK: begin
                if (tick_wait != 0) begin
                    tick_wait = tick_wait - 8'd1;
                end else if (run_flag) begin
                    mc      = run_code;
                    old_pos = servo_pos;
                    if (mc == MOVE_UP_ONCE || mc == MOVE_UP_CONT) begin
                        up_sum = {1'b0, old_pos} + {1'b0, run_step};
                        if (up_sum <= {1'b0, lim_high}) begin
                            servo_pos = up_sum[7:0];
                            clamp_from(old_pos);
                        end else begin
                            servo_pos = lim_high;
                            run_code  = MOVE_STOP;
                            run_flag  = 1'b0;
                            ended     = mc;
                        end
                    end else if (mc == MOVE_DOWN_ONCE || mc == MOVE_DOWN_CONT) begin
                        // signed so the position never wraps below zero
                        down_diff = int'(old_pos) - int'(run_step);
                        if (down_diff >= int'(lim_low)) begin
                            servo_pos = down_diff[7:0];
                            clamp_from(old_pos);
                        end else begin
                            servo_pos = lim_low;
                            run_code  = MOVE_STOP;
                            run_flag  = 1'b0;
                            ended     = mc;
                        end
                    end else begin
                        run_flag = 1'b0;
                    end
                    if (mc == MOVE_UP_ONCE || mc == MOVE_DOWN_ONCE) run_flag = 1'b0;
                    tick_wait = run_delay;
                end
            end
            REQ_CMD: begin
                run_step  = step;
                run_delay = delay;
                run_code  = apply_reverse(code);
                run_flag  = (run_code >= MOVE_UP_ONCE && run_code <= MOVE_DOWN_CONT);
                tick_wait = '0;
            end
            REQ_START: begin
                servo_pos = lim_rev ? lim_low : lim_high;
            end
            default: ;
        endcase
        res.position   = servo_pos;
        res.ended_code = ended;
        res.moving     = run_flag;
        return res;
    endfunction

    // accept monitor: track settings, predict on requests, check results
    always @(posedge aclk) begin : result_check
        ssr_result_t got;
        ssr_result_t want;
        bit          moved;
        moved = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                case (cfg_addr)
                    CFG_LOW_LIMIT:  lim_low  = cfg_data;
                    CFG_HIGH_LIMIT: lim_high = cfg_data;
                    CFG_REVERSE:    lim_rev  = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                pending_results.push_back(ramp_next(s_tuser, s_tdata[2:0],
                                                    s_tdata[10:3], s_tdata[18:11]));
            end
            if (m_tvalid === 1'b1 && m_tready) begin
                moved = 1'b1;
                got   = m_tdata[$bits(ssr_result_t)-1:0];
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result 0x%0h with nothing pending", m_tdata));
                end else begin
                    want = pending_results.pop_front();
                    if (got.position !== want.position)
                        report_mismatch($sformatf("position got %0d expected %0d",
                                                  got.position, want.position));
                    if (got.ended_code !== want.ended_code)
                        report_mismatch($sformatf("ended_code got %0d expected %0d",
                                                  got.ended_code, want.ended_code));
                    if (got.moving !== want.moving)
                        report_mismatch($sformatf("moving got %0b expected %0b",
                                                  got.moving, want.moving));
                end
            end
        end
        // watchdog on cycles with no transaction anywhere
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: long hold-offs on request, otherwise a rotating stall pattern
    always @(negedge aclk) begin
        if (long_stall_req != long_stall_seen) begin
            long_stall_seen = long_stall_req;
            stall_left      = LONG_STALL_LEN;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_pattern_e'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            cadence_cnt++;
            case (rx_mode)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
                RX_CADENCE: m_tready <= (cadence_cnt % 5) >= 2;
                default:    m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // offer one request; valid stays high across a burst
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [CODE_W-1:0] code,
                                input logic [7:0] step, input logic [7:0] delay);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap        = (steady_feed || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {5'b0, delay, step, code};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        if (burst_left > 0) burst_left--;
    endtask

    // stop offering and wait until every result is back, plus a margin
    task automatic wait_results_done();
        @(negedge aclk);
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_setting(input logic [CADDR_W-1:0] idx, input logic [POS_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(input logic [7:0] low, input logic [7:0] high,
                              input logic [7:0] rev_byte);
        wait_results_done();
        write_setting(CFG_LOW_LIMIT, low);
        write_setting(CFG_HIGH_LIMIT, high);
        write_setting(CFG_REVERSE, rev_byte);
    endtask

    // random request, mostly command-then-ticks traffic with some noise
    task automatic send_random_request();
        int                pick;
        logic [REQ_W-1:0]  req;
        logic [CODE_W-1:0] code;
        logic [7:0]        step;
        logic [7:0]        delay;
        pick  = $urandom_range(0, 99);
        code  = CODE_W'($urandom);
        step  = 8'($urandom);
        delay = 8'($urandom);
        if (pick < 65) begin
            req = REQ_TICK;
        end else if (pick < 85) begin
            req = REQ_CMD;
            if ($urandom_range(0, 9) != 0) code = CODE_W'($urandom_range(1, 4));
            if ($urandom_range(0, 4) != 0) step = 8'($urandom_range(0, 40));
            if ($urandom_range(0, 9) != 0) delay = 8'($urandom_range(0, 3));
        end else if (pick < 93) begin
            req = REQ_START;
        end else begin
            req = REQ_UNUSED;
        end
        send_request(req, code, step, delay);
    endtask

    // defaults after reset: idle tick, unused request, start, hits at both ends
    task automatic run_reset_defaults();
        send_request(REQ_TICK, MOVE_STOP, 8'd0, 8'd0);
        send_request(REQ_UNUSED, 3'd7, 8'hFF, 8'hFF);
        send_request(REQ_START, MOVE_STOP, 8'd0, 8'd0);
        send_request(REQ_CMD, MOVE_UP_ONCE, 8'd1, 8'd0);
        send_request(REQ_TICK, MOVE_STOP, 8'd0, 8'd0);
        send_request(REQ_CMD, MOVE_DOWN_CONT, 8'd255, 8'd2);
        repeat (4) send_request(REQ_TICK, MOVE_STOP, 8'd0, 8'd0);
    endtask

    // old position outside the limits, single steps, stop and unused codes
    task automatic run_limit_clamping();
        set_limits(8'd50, 8'd200, 8'd0);
        send_request(REQ_CMD, MOVE_UP_CONT, 8'd10, 8'd0);
        repeat (2) send_request(REQ_TICK, MOVE_STOP, 8'd0, 8'd0);
        send_request(REQ_CMD, MOVE_DOWN_ONCE, 8'd0, 8'd255);
        send_request(REQ_TICK, MOVE_STOP, 8'd0, 8'd0);
        send_request(REQ_CMD, MOVE_STOP, 8'd0, 8'd0);
        send_request(REQ_CMD, 3'd5, 8'd255, 8'd255);
        send_request(REQ_CMD, 3'd7, 8'd255, 8'd255);
        send_request(REQ_TICK, MOVE_STOP, 8'd0, 8'd0);
        send_request(REQ_START, MOVE_STOP, 8'd0, 8'd0);
        set_limits(8'd50, 8'd100, 8'd0);
        send_request(REQ_CMD, MOVE_DOWN_CONT, 8'd0, 8'd0);
        send_request(REQ_TICK, MOVE_STOP, 8'd0, 8'd0);
    endtask

    // swapped directions and start position
    task automatic run_reverse_direction();
        set_limits(8'd0, 8'd255, 8'd1);
        send_request(REQ_START, MOVE_STOP, 8'd0, 8'd0);
        send_request(REQ_CMD, MOVE_UP_ONCE, 8'd3, 8'd0);
        send_request(REQ_TICK, MOVE_STOP, 8'd0, 8'd0);
        send_request(REQ_CMD, MOVE_DOWN_CONT, 8'd128, 8'd0);
        repeat (2) send_request(REQ_TICK, MOVE_STOP, 8'd0, 8'd0);
        send_request(REQ_CMD, 3'd6, 8'd1, 8'd0);
        send_request(REQ_TICK, MOVE_STOP, 8'd0, 8'd0);
    endtask

    // low limit above high limit
    task automatic run_crossed_limits();
        set_limits(8'd200, 8'd50, 8'hFE);
        send_request(REQ_START, MOVE_STOP, 8'd0, 8'd0);
        send_request(REQ_CMD, MOVE_UP_CONT, 8'd5, 8'd0);
        send_request(REQ_TICK, MOVE_STOP, 8'd0, 8'd0);
        send_request(REQ_CMD, MOVE_DOWN_CONT, 8'd1, 8'd0);
        send_request(REQ_TICK, MOVE_STOP, 8'd0, 8'd0);
        repeat (15) send_random_request();
    endtask

    // receiver holds off while the sender keeps offering, then a full drain
    task automatic run_backpressure();
        set_limits(8'd10, 8'd240, 8'd0);
        steady_feed = 1'b1;
        send_request(REQ_CMD, MOVE_UP_CONT, 8'd7, 8'd0);
        long_stall_req++;
        repeat (30) send_random_request();
        steady_feed = 1'b0;
        wait_results_done();
        repeat (10) send_random_request();
    endtask

    // random phases over several settings, extremes first
    task automatic run_random_phases();
        logic [7:0] low;
        logic [7:0] high;
        logic [7:0] rev_byte;
        for (int phase = 0; phase < 10; phase++) begin
            rev_byte = {7'($urandom), 1'($urandom_range(0, 1))};
            case (phase)
                0: begin low = 8'd0;   high = 8'd255; rev_byte[0] = 1'b0; end
                1: begin low = 8'd0;   high = 8'd255; rev_byte[0] = 1'b1; end
                2: begin low = 8'd255; high = 8'd255; end
                3: begin low = 8'd0;   high = 8'd0;   end
                4: begin low = 8'd128; high = 8'd128; end
                9: begin
                    low  = 8'($urandom_range(130, 255));
                    high = 8'($urandom_range(0, 120));
                end
                default: begin
                    low  = 8'($urandom_range(0, 120));
                    high = 8'($urandom_range(130, 255));
                end
            endcase
            set_limits(low, high, rev_byte);
            steady_feed = ($urandom_range(0, 3) == 0);
            repeat (45) send_random_request();
        end
        steady_feed = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_reset_defaults();
        run_limit_clamping();
        run_reverse_direction();
        run_crossed_limits();
        run_backpressure();
        run_random_phases();

        wait_results_done();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ssr_pkg.sv
rtl/servo_step_ramp_with_limits.sv
rtl/ssr_checker.sv
tb/sv/servo_step_ramp_with_limits_tb.sv
